FILE: hw/rtl/kwea_pkg.sv
// Shared types and constants of the K-weighted energy accumulator.
// Holds the payload structs, sequencer states and fixed-point widths.
// Depends on nothing else.
`timescale 1ns / 1ps

package kwea_pkg;

    // Sample width and the left shift that aligns it to 32 fraction bits.
    localparam int SAMPLE_BITS = 24;
    localparam int X_SHIFT     = 33 - SAMPLE_BITS;

    localparam int HIST_BITS   = 48;   // filter history, 32 fraction bits
    localparam int COEF_BITS   = 32;   // Q3.29 coefficient
    localparam int FRAC_SHIFT  = 29;   // coefficient fraction bits
    localparam int PART_BITS   = 30;   // signed multiplier operand A
    localparam int MUL_B_BITS  = 33;   // signed multiplier operand B
    localparam int PROD_BITS   = PART_BITS + MUL_B_BITS;
    localparam int ACC_BITS    = 84;   // exact sum of products
    localparam int ENERGY_BITS = 64;
    localparam int SQ_LSB      = 18;   // 64 -> 46 fraction bits

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int NUM_COEF_REGS  = 5;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHTING_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE1_B0_B1        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE1_B2_A1        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE1_A2_STAGE2_B0 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE2_B1_B2        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE2_A1_A2        = 3'd5;

    // Step counter: ten products plus one drain step per biquad, three
    // products plus one drain step for the square.
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] MAC_LAST = 4'd10;
    localparam logic [STEP_BITS-1:0] SQ_LAST  = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHELF,
        ST_SHELF_RND,
        ST_HPASS,
        ST_HPASS_RND,
        ST_SQUARE,
        ST_ACCUM
    } state_t;

    // Weight of a product inside the exact accumulator.
    typedef enum logic [1:0] {
        SH_0,
        SH_29,
        SH_30,
        SH_58
    } shift_t;

    typedef struct packed {
        logic   valid;
        shift_t shift;
        logic   neg;
    } mul_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first_of_channel;
        logic                          last_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [ENERGY_BITS-1:0] energy;
        logic                   saturated;
    } out_item_t;

endpackage

FILE: hw/rtl/k_weighted_energy_accumulator.sv
// K-weighted energy accumulator: top level with sequencer and shared multiplier.
// Uses types and constants from kwea_pkg.
`timescale 1ns / 1ps

// Usage
// Samples arrive on the in_* channel (valid/ready), channel after channel. A
// transfer with first_of_channel set clears the filter history before the
// sample is used; a transfer with last_of_buffer set produces one transfer on
// the out_* channel carrying the energy sum (46 fraction bits) and the
// saturation flag, after which both are cleared.
// All arithmetic runs through one 30 x 33 bit signed multiplier followed by
// an exact 84-bit accumulator. With weighting on, an item needs 23 products
// (ten per biquad, three for the square); with weighting off only the square
// is formed. in_ready is high only while the sequencer is idle, so a new
// sample is taken only after the previous one has finished its pass.
// The result waits in an output register, so the next sample can be taken
// while the receiver stalls; only a second result stalls the sequencer until
// the first one has been transferred.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and must only occur while the block is idle. Reset selects weighting, clears
// the coefficients, the filter history, the sum and the saturation flag.
module k_weighted_energy_accumulator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  kwea_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output kwea_pkg::out_item_t                   out_data,
    input  logic                                  cfg_write,
    input  logic [kwea_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [kwea_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int HB = kwea_pkg::HIST_BITS;
    localparam int AB = kwea_pkg::ACC_BITS;

    localparam logic signed [HB-1:0] HIST_MAX = {1'b0, {(HB-1){1'b1}}};
    localparam logic signed [HB-1:0] HIST_MIN = {1'b1, {(HB-1){1'b0}}};

    // Upper part of a history value: arithmetic shift by the fraction width.
    function automatic logic signed [kwea_pkg::PART_BITS-1:0] hi_part
        (input logic signed [HB-1:0] h);
        logic signed [HB-1:0] sh;
        sh = h >>> kwea_pkg::FRAC_SHIFT;
        return sh[kwea_pkg::PART_BITS-1:0];
    endfunction

    // Lower part: the fraction bits, always non-negative.
    function automatic logic signed [kwea_pkg::PART_BITS-1:0] lo_part
        (input logic signed [HB-1:0] h);
        return {1'b0, h[kwea_pkg::FRAC_SHIFT-1:0]};
    endfunction

    function automatic logic signed [kwea_pkg::MUL_B_BITS-1:0] coef_ext
        (input logic [kwea_pkg::COEF_BITS-1:0] c);
        return {c[kwea_pkg::COEF_BITS-1], c};
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    kwea_pkg::state_t                       state_reg, state_next;
    logic [kwea_pkg::STEP_BITS-1:0]         step_reg, step_next;

    logic                                   weight_en_reg;
    logic [kwea_pkg::CFG_DATA_BITS-1:0]     coef_reg [kwea_pkg::NUM_COEF_REGS];

    logic signed [HB-1:0]                   x0_reg, y_reg, v_reg;
    logic                                   last_reg;
    logic signed [HB-1:0]                   sid1_reg, sid2_reg;
    logic signed [HB-1:0]                   sod1_reg, sod2_reg;
    logic signed [HB-1:0]                   hod1_reg, hod2_reg;

    logic signed [AB-1:0]                   acc_reg, acc_next;
    logic signed [kwea_pkg::PROD_BITS-1:0]  prod_reg;
    kwea_pkg::mul_ctl_t                     pctl_reg;

    logic [kwea_pkg::ENERGY_BITS-1:0]       energy_reg;
    logic                                   sat_reg;

    logic                                   out_valid_reg;
    kwea_pkg::out_item_t                    out_data_reg;

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    logic                                   accept;
    logic                                   emit;
    logic                                   accum_done;
    kwea_pkg::mul_ctl_t                     mctl;
    logic signed [kwea_pkg::PART_BITS-1:0]  a_op;
    logic signed [kwea_pkg::MUL_B_BITS-1:0] b_op;
    logic signed [HB-1:0]                   h_sel;
    logic [kwea_pkg::COEF_BITS-1:0]         c_sel;
    logic [2:0]                             term_idx;
    logic                                   lo_sel;

    // Datapath values
    logic signed [HB-1:0]                   x0_in;
    logic signed [kwea_pkg::PROD_BITS-1:0]  prod_full;
    logic signed [AB-1:0]                   term_base, term_shift, term;
    logic signed [AB-1:0]                   rnd_sum, rnd;
    logic                                   rnd_ovf;
    logic signed [HB-1:0]                   filt_out;
    logic                                   sq_sat;
    logic [kwea_pkg::ENERGY_BITS-1:0]       sq_val;
    logic [kwea_pkg::ENERGY_BITS:0]         sum_wide;
    logic [kwea_pkg::ENERGY_BITS-1:0]       energy_new;
    logic                                   sat_new;

    assign accept   = in_valid && in_ready;
    assign term_idx = step_reg[3:1];
    assign lo_sel   = step_reg[0];

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            kwea_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = weight_en_reg ? kwea_pkg::ST_SHELF : kwea_pkg::ST_SQUARE;
                end
            end
            kwea_pkg::ST_SHELF:
            begin
                if (step_reg == kwea_pkg::MAC_LAST)
                begin
                    state_next = kwea_pkg::ST_SHELF_RND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            kwea_pkg::ST_SHELF_RND:
            begin
                step_next  = '0;
                state_next = kwea_pkg::ST_HPASS;
            end
            kwea_pkg::ST_HPASS:
            begin
                if (step_reg == kwea_pkg::MAC_LAST)
                begin
                    state_next = kwea_pkg::ST_HPASS_RND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            kwea_pkg::ST_HPASS_RND:
            begin
                step_next  = '0;
                state_next = kwea_pkg::ST_SQUARE;
            end
            kwea_pkg::ST_SQUARE:
            begin
                if (step_reg == kwea_pkg::SQ_LAST)
                begin
                    state_next = kwea_pkg::ST_ACCUM;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            kwea_pkg::ST_ACCUM:
            begin
                if (!(last_reg && out_valid_reg && !out_ready))
                begin
                    state_next = kwea_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwea_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: operand selection for the shared multiplier.
    // Each biquad term h*c is split into (hi(h)*c << 29) + lo(h)*c, so the
    // accumulator holds the exact sum; feedback terms are subtracted.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready   = (state_reg == kwea_pkg::ST_IDLE);
        emit       = 1'b0;
        accum_done = 1'b0;
        mctl       = '{valid: 1'b0, shift: kwea_pkg::SH_0, neg: 1'b0};
        h_sel      = '0;
        c_sel      = '0;
        a_op       = '0;
        b_op       = '0;
        unique case (state_reg)
            kwea_pkg::ST_SHELF:
            begin
                unique case (term_idx)
                    3'd0:    begin h_sel = x0_reg;   c_sel = coef_reg[0][63:32]; end
                    3'd1:    begin h_sel = sid1_reg; c_sel = coef_reg[0][31:0];  end
                    3'd2:    begin h_sel = sid2_reg; c_sel = coef_reg[1][63:32]; end
                    3'd3:    begin h_sel = sod1_reg; c_sel = coef_reg[1][31:0];  end
                    3'd4:    begin h_sel = sod2_reg; c_sel = coef_reg[2][63:32]; end
                    default: begin h_sel = '0;       c_sel = '0;                 end
                endcase
                mctl.valid = (step_reg != kwea_pkg::MAC_LAST);
                mctl.shift = lo_sel ? kwea_pkg::SH_0 : kwea_pkg::SH_29;
                mctl.neg   = (term_idx >= 3'd3);
                a_op       = lo_sel ? lo_part(h_sel) : hi_part(h_sel);
                b_op       = coef_ext(c_sel);
            end
            kwea_pkg::ST_HPASS:
            begin
                unique case (term_idx)
                    3'd0:    begin h_sel = y_reg;    c_sel = coef_reg[2][31:0];  end
                    3'd1:    begin h_sel = sod1_reg; c_sel = coef_reg[3][63:32]; end
                    3'd2:    begin h_sel = sod2_reg; c_sel = coef_reg[3][31:0];  end
                    3'd3:    begin h_sel = hod1_reg; c_sel = coef_reg[4][63:32]; end
                    3'd4:    begin h_sel = hod2_reg; c_sel = coef_reg[4][31:0];  end
                    default: begin h_sel = '0;       c_sel = '0;                 end
                endcase
                mctl.valid = (step_reg != kwea_pkg::MAC_LAST);
                mctl.shift = lo_sel ? kwea_pkg::SH_0 : kwea_pkg::SH_29;
                mctl.neg   = (term_idx >= 3'd3);
                a_op       = lo_sel ? lo_part(h_sel) : hi_part(h_sel);
                b_op       = coef_ext(c_sel);
            end
            kwea_pkg::ST_SQUARE:
            begin
                // v^2 = hi*hi << 58 + hi*lo << 30 + lo*lo
                mctl.valid = (step_reg != kwea_pkg::SQ_LAST);
                unique case (step_reg[1:0])
                    2'd0:
                    begin
                        a_op       = hi_part(v_reg);
                        b_op       = kwea_pkg::MUL_B_BITS'(hi_part(v_reg));
                        mctl.shift = kwea_pkg::SH_58;
                    end
                    2'd1:
                    begin
                        a_op       = hi_part(v_reg);
                        b_op       = kwea_pkg::MUL_B_BITS'(lo_part(v_reg));
                        mctl.shift = kwea_pkg::SH_30;
                    end
                    2'd2:
                    begin
                        a_op       = lo_part(v_reg);
                        b_op       = kwea_pkg::MUL_B_BITS'(lo_part(v_reg));
                        mctl.shift = kwea_pkg::SH_0;
                    end
                    default:
                    begin
                        a_op       = '0;
                        b_op       = '0;
                        mctl.shift = kwea_pkg::SH_0;
                    end
                endcase
            end
            kwea_pkg::ST_ACCUM:
            begin
                accum_done = !(last_reg && out_valid_reg && !out_ready);
                emit       = accum_done && last_reg;
            end
            default:
            begin
                mctl.valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath arithmetic
    // ------------------------------------------------------------------
    assign x0_in     = HB'(in_data.sample) <<< kwea_pkg::X_SHIFT;
    assign prod_full = a_op * b_op;

    assign term_base = AB'(prod_reg);
    always_comb
    begin
        unique case (pctl_reg.shift)
            kwea_pkg::SH_0:  term_shift = term_base;
            kwea_pkg::SH_29: term_shift = term_base <<< 29;
            kwea_pkg::SH_30: term_shift = term_base <<< 30;
            kwea_pkg::SH_58: term_shift = term_base <<< 58;
            default:         term_shift = term_base;
        endcase
        term = pctl_reg.neg ? -term_shift : term_shift;
    end

    // The square stays in the accumulator while a result waits in ACCUM;
    // the idle cycle that always follows clears it.
    always_comb
    begin
        priority if (state_reg == kwea_pkg::ST_IDLE || state_reg == kwea_pkg::ST_SHELF_RND ||
                     state_reg == kwea_pkg::ST_HPASS_RND)
        begin
            acc_next = '0;
        end
        else if (pctl_reg.valid)
        begin
            acc_next = acc_reg + term;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    // Round to nearest (ties up) by 29 bits, then saturate to 48 bits.
    assign rnd_sum  = acc_reg + (AB'(1) <<< (kwea_pkg::FRAC_SHIFT - 1));
    assign rnd      = rnd_sum >>> kwea_pkg::FRAC_SHIFT;
    assign rnd_ovf  = !((&rnd[AB-1:HB-1]) || !(|rnd[AB-1:HB-1]));
    assign filt_out = rnd_ovf ? (rnd[AB-1] ? HIST_MIN : HIST_MAX) : rnd[HB-1:0];

    // The square saturates once |v| reaches 2^41.
    assign sq_sat   = !((&v_reg[HB-1:41]) || !(|v_reg[HB-1:41])) ||
                      (v_reg == {{(HB-41){1'b1}}, 41'd0});
    assign sq_val   = sq_sat ? '1 : acc_reg[kwea_pkg::SQ_LSB +: kwea_pkg::ENERGY_BITS];
    assign sum_wide = {1'b0, energy_reg} + {1'b0, sq_val};
    assign energy_new = sum_wide[kwea_pkg::ENERGY_BITS] ? '1 :
                        sum_wide[kwea_pkg::ENERGY_BITS-1:0];
    assign sat_new  = sat_reg || sq_sat || sum_wide[kwea_pkg::ENERGY_BITS];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kwea_pkg::ST_IDLE;
            step_reg      <= '0;
            pctl_reg      <= '{valid: 1'b0, shift: kwea_pkg::SH_0, neg: 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pctl_reg  <= mctl;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_en_reg <= 1'b1;
            for (int i = 0; i < kwea_pkg::NUM_COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kwea_pkg::REG_WEIGHTING_ENABLE:    weight_en_reg <= cfg_data[0];
                kwea_pkg::REG_STAGE1_B0_B1:        coef_reg[0]   <= cfg_data;
                kwea_pkg::REG_STAGE1_B2_A1:        coef_reg[1]   <= cfg_data;
                kwea_pkg::REG_STAGE1_A2_STAGE2_B0: coef_reg[2]   <= cfg_data;
                kwea_pkg::REG_STAGE2_B1_B2:        coef_reg[3]   <= cfg_data;
                kwea_pkg::REG_STAGE2_A1_A2:        coef_reg[4]   <= cfg_data;
                default:                           weight_en_reg <= weight_en_reg;
            endcase
        end
    end

    // Architectural state: filter history, energy sum and saturation flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sid1_reg   <= '0;
            sid2_reg   <= '0;
            sod1_reg   <= '0;
            sod2_reg   <= '0;
            hod1_reg   <= '0;
            hod2_reg   <= '0;
            energy_reg <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            priority if (accept && in_data.first_of_channel)
            begin
                sid1_reg <= '0;
                sid2_reg <= '0;
                sod1_reg <= '0;
                sod2_reg <= '0;
                hod1_reg <= '0;
                hod2_reg <= '0;
            end
            else if (state_reg == kwea_pkg::ST_HPASS_RND)
            begin
                sid2_reg <= sid1_reg;
                sid1_reg <= x0_reg;
                sod2_reg <= sod1_reg;
                sod1_reg <= y_reg;
                hod2_reg <= hod1_reg;
                hod1_reg <= filt_out;
            end
            else
            begin
                sid1_reg <= sid1_reg;
            end

            priority if (emit)
            begin
                energy_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else if (accum_done)
            begin
                energy_reg <= energy_new;
                sat_reg    <= sat_new;
            end
            else if ((state_reg == kwea_pkg::ST_SHELF_RND ||
                      state_reg == kwea_pkg::ST_HPASS_RND) && rnd_ovf)
            begin
                sat_reg <= 1'b1;
            end
            else
            begin
                sat_reg <= sat_reg;
            end
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_full;
        if (accept)
        begin
            x0_reg   <= x0_in;
            v_reg    <= x0_in;
            last_reg <= in_data.last_of_buffer;
        end
        if (state_reg == kwea_pkg::ST_SHELF_RND)
        begin
            y_reg <= filt_out;
        end
        if (state_reg == kwea_pkg::ST_HPASS_RND)
        begin
            v_reg <= filt_out;
        end
        if (emit)
        begin
            out_data_reg.energy    <= energy_new;
            out_data_reg.saturated <= sat_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwea_pkg::ST_SHELF || state_reg == kwea_pkg::ST_HPASS)
            |-> step_reg <= kwea_pkg::MAC_LAST)
        else $error("step counter ran past the biquad schedule");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == kwea_pkg::ST_SHELF || state_reg == kwea_pkg::ST_HPASS) &&
         step_reg == '0) |-> acc_reg == '0)
        else $error("accumulator not cleared at start of a biquad");

    a_prod_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pctl_reg.valid |-> (state_reg == kwea_pkg::ST_SHELF ||
                            state_reg == kwea_pkg::ST_HPASS ||
                            state_reg == kwea_pkg::ST_SQUARE))
        else $error("product arrived outside a multiply phase");

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !weight_en_reg) |=> state_reg == kwea_pkg::ST_SQUARE)
        else $error("bypassed sample did not go straight to the square");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && energy_reg == '0 && !sat_reg))
        else $error("emission did not load the output and clear the sum");

endmodule

FILE: tb/k_weighted_energy_accumulator_tb.sv
// Self-checking testbench for the K-weighted energy accumulator.
// Holds a scoreboard class with a bit-exact predictor, plus the stimulus and watchdog.
// Depends on kwea_pkg and the k_weighted_energy_accumulator RTL.
`timescale 1ns / 1ps

module k_weighted_energy_accumulator_tb;
    import kwea_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES  = 40;    // outlasts the longest item's pass
    localparam int SEGMENTS       = 15;
    localparam int SEGMENT_ITEMS  = 64;

    // Indexes beyond the last register; writes to them must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX  = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN  = 24'sh80_0000;
    localparam logic signed [SAMPLE_BITS-1:0] HALF_STEP   = 24'sh08_0000;
    localparam logic signed [SAMPLE_BITS-1:0] HALF_STEP_N = 24'shF8_0000;
    localparam logic signed [SAMPLE_BITS-1:0] TRIPLE_HALF = 24'sh18_0000;
    localparam logic signed [SAMPLE_BITS-1:0] TRIPLE_HALF_N = 24'shE8_0000;

    // Broadcast K-weighting at 48 kHz, Q3.29, packed two per register.
    localparam logic [63:0] KW_R1 = {32'sd824163884, -32'sd1445093379};
    localparam logic [63:0] KW_R2 = {32'sd643382241, -32'sd907665796};
    localparam logic [63:0] KW_R3 = {32'sd393247621, 32'sd536870912};
    localparam logic [63:0] KW_R4 = {-32'sd1073741824, 32'sd536870912};
    localparam logic [63:0] KW_R5 = {-32'sd1068398591, 32'sd531540992};

    // Shelf b0 of one plus one LSB makes the rounding land exactly on a half
    // for samples that are odd multiples of 2^19; the high-pass passes it on.
    localparam logic [63:0] TIE_R1 = {32'sh2000_0001, 32'sd0};
    localparam logic [63:0] TIE_R3 = {32'sd0, 32'sh2000_0000};

    localparam logic [63:0] PEAK_POS = 64'h7FFF_FFFF_7FFF_FFFF;
    localparam logic [63:0] PEAK_NEG = 64'h8000_0000_8000_0000;

    typedef enum int {
        STYLE_KWEIGHT,
        STYLE_RAW,
        STYLE_WILD,
        STYLE_MILD,
        STYLE_PEAK_POS,
        STYLE_PEAK_NEG,
        STYLE_ROUNDING
    } coef_style_t;

    typedef bit signed [127:0] wide_t;

    // Tracks the block's registers and filter state, predicts the energy
    // reports and compares them with what comes out.
    class energy_scoreboard;
        bit                 weighting = 1'b1;
        bit [63:0]          coef_word [5];
        bit signed [47:0]   shelf_x1, shelf_x2, shelf_y1, shelf_y2;
        bit signed [47:0]   hp_y1, hp_y2;
        bit [63:0]          energy_sum;
        bit                 sat_seen;
        out_item_t          energy_due [$];
        int                 faults;

        function bit signed [32:0] coef(int slot, bit upper);
            bit [31:0] half;
            half = upper ? coef_word[slot][63:32] : coef_word[slot][31:0];
            return {half[31], half};
        endfunction

        // One Direct Form I section: exact sum, round half up by 29 bits,
        // clamp to the 48-bit history range.
        function bit signed [47:0] biquad(bit signed [47:0] x0, x1, x2, y1, y2,
                                          bit signed [32:0] b0, b1, b2, a1, a2);
            wide_t acc;
            acc = x0 * b0 + x1 * b1 + x2 * b2 - y1 * a1 - y2 * a2;
            acc = (acc + (wide_t'(1) <<< 28)) >>> 29;
            if (acc > 48'sh7FFF_FFFF_FFFF)
            begin
                sat_seen = 1'b1;
                return 48'sh7FFF_FFFF_FFFF;
            end
            if (acc < 48'sh8000_0000_0000)
            begin
                sat_seen = 1'b1;
                return 48'sh8000_0000_0000;
            end
            return acc[47:0];
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_WEIGHTING_ENABLE:    weighting    = value[0];
                REG_STAGE1_B0_B1:        coef_word[0] = value;
                REG_STAGE1_B2_A1:        coef_word[1] = value;
                REG_STAGE1_A2_STAGE2_B0: coef_word[2] = value;
                REG_STAGE2_B1_B2:        coef_word[3] = value;
                REG_STAGE2_A1_A2:        coef_word[4] = value;
                default: ;
            endcase
        endfunction

        function void take_sample(in_item_t item);
            bit signed [47:0] x0, y, z, val;
            bit [47:0]        mag;
            bit [95:0]        prod;
            bit [63:0]        sq;
            bit [64:0]        total;
            out_item_t        report;
            x0 = $signed(item.sample);
            x0 = x0 <<< X_SHIFT;
            if (item.first_of_channel)
            begin
                shelf_x1 = '0; shelf_x2 = '0;
                shelf_y1 = '0; shelf_y2 = '0;
                hp_y1    = '0; hp_y2    = '0;
            end
            if (weighting)
            begin
                y = biquad(x0, shelf_x1, shelf_x2, shelf_y1, shelf_y2,
                           coef(0, 1), coef(0, 0), coef(1, 1), coef(1, 0), coef(2, 1));
                z = biquad(y, shelf_y1, shelf_y2, hp_y1, hp_y2,
                           coef(2, 0), coef(3, 1), coef(3, 0), coef(4, 1), coef(4, 0));
                shelf_x2 = shelf_x1;
                shelf_x1 = x0;
                shelf_y2 = shelf_y1;
                shelf_y1 = y;
                hp_y2    = hp_y1;
                hp_y1    = z;
                val      = z;
            end
            else
            begin
                val = x0;
            end
            // Square with 64 fraction bits, floored to 46; anything from 2^41
            // up no longer fits and pins the square at all ones.
            mag = (val < 0) ? -val : val;
            if (mag >= 48'h200_0000_0000)
            begin
                sat_seen = 1'b1;
                sq = '1;
            end
            else
            begin
                prod = mag * mag;
                sq   = prod[81:18];
            end
            total = {1'b0, energy_sum} + {1'b0, sq};
            if (total[64])
            begin
                energy_sum = '1;
                sat_seen   = 1'b1;
            end
            else
            begin
                energy_sum = total[63:0];
            end
            if (item.last_of_buffer)
            begin
                report.energy    = energy_sum;
                report.saturated = sat_seen;
                energy_due.push_back(report);
                energy_sum = '0;
                sat_seen   = 1'b0;
            end
        endfunction

        function void note_fault(string msg);
            if (faults < 10)
                $display("mismatch at %0t: %s", $realtime, msg);
            faults++;
        endfunction

        function void check_energy(out_item_t got);
            out_item_t want;
            if (energy_due.size() == 0)
            begin
                note_fault($sformatf("unexpected report energy %h saturated %0b",
                                     got.energy, got.saturated));
                return;
            end
            want = energy_due.pop_front();
            if (got.energy !== want.energy)
                note_fault($sformatf("energy expected %h got %h", want.energy, got.energy));
            if (got.saturated !== want.saturated)
                note_fault($sformatf("saturated expected %0b got %0b",
                                     want.saturated, got.saturated));
        endfunction

        function int pending();
            return energy_due.size();
        endfunction
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    in_item_t                    in_data   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    out_item_t                   out_data;
    logic                        cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data  = '0;

    int               send_gap_pct = 0;
    int               recv_gap_pct = 0;
    int               idle_cycles  = 0;
    energy_scoreboard sb;

    k_weighted_energy_accumulator u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random; with a zero rate it is always ready.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Every result transfer is checked against the oldest prediction. The
    // watchdog ends the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_energy(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles++;
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        case ($urandom_range(15))
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            default: v = v >>> $urandom_range(SAMPLE_BITS - 1);
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Two coefficients of at most one half in magnitude: usually a stable filter.
    function automatic logic [63:0] mild_word();
        return {32'($signed($urandom) >>> 3), 32'($signed($urandom) >>> 3)};
    endfunction

    // Presents one sample and returns at the falling edge after its transfer,
    // with valid still high so that the next sample can follow at once.
    task automatic feed(input logic signed [SAMPLE_BITS-1:0] value,
                        input bit first, input bit last);
        in_item_t item;
        item.sample           = value;
        item.first_of_channel = first;
        item.last_of_buffer   = last;
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        sb.take_sample(item);
        @(negedge clk);
    endtask

    // Drops valid, waits for every outstanding report, then lets a sample
    // without a report finish its pass so the block is idle.
    task automatic finish_traffic();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all registers, then junk to the two unused indexes.
    task automatic program_block(input bit enable, input logic [63:0] b0b1, b2a1,
                                 input logic [63:0] a2b0, hp_b1b2, hp_a1a2);
        logic [CFG_INDEX_BITS-1:0] idx [8];
        logic [CFG_DATA_BITS-1:0]  val [8];
        idx = '{REG_WEIGHTING_ENABLE, REG_STAGE1_B0_B1, REG_STAGE1_B2_A1,
                REG_STAGE1_A2_STAGE2_B0, REG_STAGE2_B1_B2, REG_STAGE2_A1_A2,
                REG_SPARE_6, REG_SPARE_7};
        val = '{{32'($urandom), 31'($urandom), enable}, b0b1, b2a1, a2b0,
                hp_b1b2, hp_a1a2, rand_word(), rand_word()};
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic apply_style(input coef_style_t style);
        case (style)
            STYLE_KWEIGHT:
                program_block(1'b1, KW_R1, KW_R2, KW_R3, KW_R4, KW_R5);
            STYLE_RAW:
                program_block(1'b0, rand_word(), rand_word(), rand_word(),
                              rand_word(), rand_word());
            STYLE_WILD:
                program_block(1'b1, rand_word(), rand_word(), rand_word(),
                              rand_word(), rand_word());
            STYLE_MILD:
                program_block(1'b1, mild_word(), mild_word(), mild_word(),
                              mild_word(), mild_word());
            STYLE_PEAK_POS:
                program_block(1'b1, PEAK_POS, PEAK_POS, PEAK_POS, PEAK_POS, PEAK_POS);
            STYLE_PEAK_NEG:
                program_block(1'b1, PEAK_NEG, PEAK_NEG, PEAK_NEG, PEAK_NEG, PEAK_NEG);
            STYLE_ROUNDING:
                program_block(1'b1, TIE_R1, '0, TIE_R3, '0, '0);
        endcase
    endtask

    // A buffer is one to three channels, each opened by a first-of-channel
    // mark, and closed by a last-of-buffer mark. One buffer in eight gets
    // random marks instead.
    task automatic play_buffer(inout int fed);
        int chans;
        int len;
        bit noisy;
        noisy = ($urandom_range(7) == 0);
        chans = $urandom_range(3, 1);
        for (int c = 0; c < chans; c++)
        begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
            begin
                if (noisy)
                    feed(pick_sample(), $urandom_range(3) == 0, $urandom_range(3) == 0);
                else
                    feed(pick_sample(), i == 0, (c == chans - 1) && (i == len - 1));
                fed++;
            end
        end
    endtask

    initial
    begin
        int fed;
        sb = new;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset state: weighting on with zero coefficients yields no energy.
        feed(SAMPLE_MAX, 1'b1, 1'b0);
        feed(SAMPLE_MIN, 1'b0, 1'b1);
        finish_traffic();

        // Build some filter history with the real weighting curve.
        apply_style(STYLE_KWEIGHT);
        feed(SAMPLE_MAX, 1'b1, 1'b0);
        feed(SAMPLE_MIN, 1'b0, 1'b0);
        feed(SAMPLE_MAX, 1'b0, 1'b1);
        finish_traffic();

        // Plain energy at the sample extremes; the channel mark here must
        // still wipe the history even though the filters are bypassed.
        apply_style(STYLE_RAW);
        feed(SAMPLE_MAX, 1'b0, 1'b0);
        feed(SAMPLE_MIN, 1'b1, 1'b0);
        feed(-24'sd1, 1'b0, 1'b0);
        feed(24'sd1, 1'b0, 1'b1);
        finish_traffic();

        // Weighting back on without a channel mark: old history would show.
        apply_style(STYLE_KWEIGHT);
        feed(SAMPLE_MAX, 1'b0, 1'b1);
        finish_traffic();

        // Exact half-way rounding, positive and negative, one report each.
        apply_style(STYLE_ROUNDING);
        feed(HALF_STEP, 1'b1, 1'b1);
        feed(HALF_STEP_N, 1'b1, 1'b1);
        feed(TRIPLE_HALF, 1'b0, 1'b1);
        feed(TRIPLE_HALF_N, 1'b0, 1'b1);
        feed(SAMPLE_MAX, 1'b1, 1'b1);
        feed(SAMPLE_MIN, 1'b1, 1'b1);
        finish_traffic();

        // Runaway filter: history, square and sum all saturate. The buffer
        // after the report must start again from zero with a clear flag.
        apply_style(STYLE_PEAK_NEG);
        for (int i = 0; i < 6; i++)
            feed(SAMPLE_MAX, i == 0, i == 5);
        feed(24'sd0, 1'b1, 1'b1);
        finish_traffic();

        // Random buffers: the weighting, raw, wild, mild and positive-peak styles under each idling pattern.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_gap_pct = (seg / 5 == 0) ? 16 : (seg / 5 == 1) ? 64 : 0;
            recv_gap_pct = (seg / 5 == 0) ? 64 : (seg / 5 == 1) ? 16 : 0;
            apply_style(coef_style_t'(seg % 5));
            fed = 0;
            while (fed < SEGMENT_ITEMS)
                play_buffer(fed);
            finish_traffic();
        end

        if (sb.faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/kwea_pkg.sv
hw/rtl/k_weighted_energy_accumulator.sv
tb/k_weighted_energy_accumulator_tb.sv
